// ===== sv/dvr_pkg.sv =====
// ============================================================================
// dvr_pkg
// Shared widths, register indexes, command/config types and the 2^x table
// for the decibel volume ramp.
// ============================================================================
`default_nettype none

package dvr_pkg;

    localparam int LEVEL_W     = 24;
    localparam int GAIN_W      = 20;
    localparam int STEP_W      = 16;
    localparam int COUNT_W     = 13;
    localparam int AMT_W       = STEP_W + COUNT_W;
    localparam int ACC_W       = AMT_W + 3;
    localparam int FRAC_BITS   = 16;
    localparam int TAB_ENTRIES = 256;
    localparam int IDX_W       = $clog2(TAB_ENTRIES);
    localparam int REM_W       = 24;
    localparam int MANT_W      = 32;
    localparam int K_W         = 30;
    localparam int E_W         = LEVEL_W + K_W;
    localparam int SH          = 32 + FRAC_BITS;
    localparam int IP_W        = E_W - SH;
    localparam int S_W         = IP_W + 1;
    localparam int SHAMT_W     = $clog2(MANT_W) + 1;
    localparam int PROD_W      = MANT_W + REM_W;
    localparam int IDX_W_ONE   = IDX_W + 1;

    // log2(10)/20 in Q32
    localparam logic [K_W-1:0] DB_TO_LOG2 = 30'd713378626;
    // gain = mantissa(Q30) * 2^(ip + FRAC_BITS - 30)
    localparam logic signed [S_W-1:0] S_OFFSET = S_W'(FRAC_BITS - 30);

    localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

    localparam logic signed [LEVEL_W-1:0] MIN_LEVEL_RESET = -24'sd3145728;
    localparam logic signed [LEVEL_W-1:0] MAX_LEVEL_RESET = 24'sd0;
    localparam logic [STEP_W-1:0]         RAMP_STEP_RESET = 16'd179;

    // register indexes
    localparam logic [1:0] REG_MIN_LEVEL = 2'd0;
    localparam logic [1:0] REG_MAX_LEVEL = 2'd1;
    localparam logic [1:0] REG_RAMP_STEP = 2'd2;

    // item functions
    localparam logic FUNC_ADVANCE = 1'b0;
    localparam logic FUNC_SET     = 1'b1;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] min_level;
        logic signed [LEVEL_W-1:0] max_level;
        logic [STEP_W-1:0]         ramp_step;
    } cfg_t;

    typedef struct packed {
        logic accept;    // capture item, clamp target, form step amount
        logic step;      // move level toward target
        logic expo;      // level to log2 exponent
        logic interp;    // table read and slope multiply
        logic load_out;  // result into output register
    } cmd_t;

    typedef logic [MANT_W-1:0] pow2_tab_t [TAB_ENTRIES+1];

    // 2^(i/TAB_ENTRIES) in Q30, Taylor series of exp(i*ln2/N) in Q32
    function automatic logic [MANT_W-1:0] pow2_entry(input int unsigned i);
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] sum;
        y    = (64'd2977044472 * 64'(i)) / 64'(TAB_ENTRIES);
        term = 64'h1_0000_0000;
        sum  = term;
        for (int k = 1; k <= 20; k++)
        begin
            term = ((term * y) >> 32) / 64'(k);
            sum  = sum + term;
        end
        return MANT_W'((sum + 64'd2) >> 2);
    endfunction

    function automatic pow2_tab_t build_pow2_tab();
        pow2_tab_t t;
        for (int i = 0; i <= TAB_ENTRIES; i++)
        begin
            t[i] = pow2_entry(i);
        end
        return t;
    endfunction

    localparam pow2_tab_t POW2_TAB = build_pow2_tab();

endpackage

`default_nettype wire

// ===== sv/dvr_in_if.sv =====
// ============================================================================
// dvr_in_if
// Input item channel: valid/ready with function, target and sample count.
// ============================================================================
`default_nettype none

interface dvr_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  func;
    logic signed [dvr_pkg::LEVEL_W-1:0]    new_target;
    logic [dvr_pkg::COUNT_W-1:0]           sample_count;

    modport source (output valid, output func, output new_target,
                    output sample_count, input ready);
    modport sink   (input valid, input func, input new_target,
                    input sample_count, output ready);
endinterface

`default_nettype wire

// ===== sv/dvr_out_if.sv =====
// ============================================================================
// dvr_out_if
// Result channel: valid/ready with current level, target level and gain.
// ============================================================================
`default_nettype none

interface dvr_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [dvr_pkg::LEVEL_W-1:0]    current_level;
    logic signed [dvr_pkg::LEVEL_W-1:0]    target_level;
    logic [dvr_pkg::GAIN_W-1:0]            linear_gain;

    modport source (output valid, output current_level, output target_level,
                    output linear_gain, input ready);
    modport sink   (input valid, input current_level, input target_level,
                    input linear_gain, output ready);
endinterface

`default_nettype wire

// ===== sv/dvr_ctrl.sv =====
// ============================================================================
// dvr_ctrl
// Sequencer for one item at a time plus the result valid flag.
// ============================================================================
`default_nettype none

module dvr_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    output dvr_pkg::cmd_t       cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_STEP   = 3'd1;
    localparam logic [2:0] S_EXP    = 3'd2;
    localparam logic [2:0] S_INTERP = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = S_EXP;
            end
            S_EXP:
            begin
                cmd.expo   = 1'b1;
                state_next = S_INTERP;
            end
            S_INTERP:
            begin
                cmd.interp = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold here until the output register can take the result
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/dvr_datapath.sv =====
// ============================================================================
// dvr_datapath
// Level and target state, ramp arithmetic and dB-to-linear gain pipeline.
// ============================================================================
`default_nettype none

module dvr_datapath
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire dvr_pkg::cmd_t                      cmd,
    input  wire dvr_pkg::cfg_t                      cfg,
    input  wire logic                               func,
    input  wire logic signed [dvr_pkg::LEVEL_W-1:0] new_target,
    input  wire logic [dvr_pkg::COUNT_W-1:0]        sample_count,
    output logic signed [dvr_pkg::LEVEL_W-1:0]      current_level,
    output logic signed [dvr_pkg::LEVEL_W-1:0]      target_level,
    output logic [dvr_pkg::GAIN_W-1:0]              linear_gain
);

    // state
    logic signed [dvr_pkg::LEVEL_W-1:0] level_now_reg;
    logic signed [dvr_pkg::LEVEL_W-1:0] level_now_next;
    logic signed [dvr_pkg::LEVEL_W-1:0] level_goal_reg;
    logic signed [dvr_pkg::LEVEL_W-1:0] level_goal_next;

    // item capture
    logic                               func_reg;
    logic [dvr_pkg::AMT_W-1:0]          amt_reg;
    logic [dvr_pkg::AMT_W-1:0]          amt_next;
    logic signed [dvr_pkg::LEVEL_W-1:0] clamp_lo;
    logic signed [dvr_pkg::LEVEL_W-1:0] clamp_val;

    // ramp
    logic signed [dvr_pkg::ACC_W-1:0]   cur_ext;
    logic signed [dvr_pkg::ACC_W-1:0]   goal_ext;
    logic signed [dvr_pkg::ACC_W-1:0]   amt_ext;
    logic signed [dvr_pkg::ACC_W-1:0]   up_sum;
    logic signed [dvr_pkg::ACC_W-1:0]   dn_sum;

    // gain pipeline
    logic signed [dvr_pkg::E_W-1:0]     e_reg;
    logic signed [dvr_pkg::E_W-1:0]     e_next;
    logic                               mute_reg;
    logic                               mute_p_reg;
    logic [dvr_pkg::IDX_W-1:0]          idx;
    logic [dvr_pkg::IDX_W_ONE-1:0]      idx_hi;
    logic [dvr_pkg::REM_W-1:0]          rem;
    logic [dvr_pkg::MANT_W-1:0]         tab_lo;
    logic [dvr_pkg::MANT_W-1:0]         tab_hi;
    logic [dvr_pkg::MANT_W-1:0]         diff;
    logic signed [dvr_pkg::IP_W-1:0]    ip;
    logic [dvr_pkg::MANT_W-1:0]         lo_reg;
    logic [dvr_pkg::PROD_W-1:0]         prod_reg;
    logic [dvr_pkg::PROD_W-1:0]         prod_next;
    logic signed [dvr_pkg::S_W-1:0]     s_reg;
    logic signed [dvr_pkg::S_W-1:0]     s_next;
    logic [dvr_pkg::MANT_W-1:0]         mant;
    logic [dvr_pkg::S_W-1:0]            neg_s;
    logic [dvr_pkg::MANT_W-1:0]         shifted;
    logic [dvr_pkg::GAIN_W-1:0]         gain_val;

    // output register
    logic signed [dvr_pkg::LEVEL_W-1:0] cur_out_reg;
    logic signed [dvr_pkg::LEVEL_W-1:0] goal_out_reg;
    logic [dvr_pkg::GAIN_W-1:0]         gain_out_reg;

    // ---- accept: clamp target, raise then lower; form step amount
    always_comb
    begin
        clamp_lo  = (new_target < cfg.min_level) ? cfg.min_level : new_target;
        clamp_val = (clamp_lo > cfg.max_level) ? cfg.max_level : clamp_lo;
        amt_next  = dvr_pkg::AMT_W'(cfg.ramp_step) * dvr_pkg::AMT_W'(sample_count);
    end

    // ---- step: move toward target without passing it
    always_comb
    begin
        cur_ext  = dvr_pkg::ACC_W'(level_now_reg);
        goal_ext = dvr_pkg::ACC_W'(level_goal_reg);
        amt_ext  = signed'({3'b000, amt_reg});
        up_sum   = cur_ext + amt_ext;
        dn_sum   = cur_ext - amt_ext;
        level_now_next = level_now_reg;
        if (cur_ext < goal_ext)
        begin
            level_now_next = (up_sum > goal_ext) ? level_goal_reg
                                                 : dvr_pkg::LEVEL_W'(up_sum);
        end
        else
        begin
            level_now_next = (dn_sum < goal_ext) ? level_goal_reg
                                                 : dvr_pkg::LEVEL_W'(dn_sum);
        end
    end

    assign level_goal_next = clamp_val;

    // ---- exponent: level * log2(10)/20
    assign e_next = dvr_pkg::E_W'(level_now_reg) *
                    signed'({1'b0, dvr_pkg::DB_TO_LOG2});

    // ---- table lookup and slope product
    always_comb
    begin
        ip        = dvr_pkg::IP_W'(e_reg >>> dvr_pkg::SH);
        idx       = e_reg[dvr_pkg::SH-1 -: dvr_pkg::IDX_W];
        rem       = e_reg[dvr_pkg::SH-1-dvr_pkg::IDX_W -: dvr_pkg::REM_W];
        idx_hi    = dvr_pkg::IDX_W_ONE'(idx) + dvr_pkg::IDX_W_ONE'(1);
        tab_lo    = dvr_pkg::POW2_TAB[idx];
        tab_hi    = dvr_pkg::POW2_TAB[idx_hi];
        diff      = (tab_hi >= tab_lo) ? (tab_hi - tab_lo) : '0;
        prod_next = dvr_pkg::PROD_W'(diff) * dvr_pkg::PROD_W'(rem);
        s_next    = dvr_pkg::S_W'(ip) + dvr_pkg::S_OFFSET;
    end

    // ---- mantissa and scaling; low bits kept when the shift leaves more
    always_comb
    begin
        mant    = lo_reg + dvr_pkg::MANT_W'(prod_reg >> dvr_pkg::REM_W);
        neg_s   = dvr_pkg::S_W'(-s_reg);
        shifted = (neg_s >= dvr_pkg::S_W'(dvr_pkg::MANT_W)) ? '0 : (mant >> neg_s);
        if (mute_p_reg)
        begin
            gain_val = '0;
        end
        else if (s_reg >= 0)
        begin
            // mantissa is at least 2^30, so any left shift saturates
            gain_val = dvr_pkg::GAIN_MAX;
        end
        else
        begin
            gain_val = shifted[dvr_pkg::GAIN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_now_reg  <= dvr_pkg::MIN_LEVEL_RESET;
            level_goal_reg <= dvr_pkg::MIN_LEVEL_RESET;
        end
        else
        begin
            if (cmd.accept && (func == dvr_pkg::FUNC_SET))
            begin
                level_goal_reg <= level_goal_next;
            end
            if (cmd.step && (func_reg == dvr_pkg::FUNC_ADVANCE))
            begin
                level_now_reg <= level_now_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg <= func;
            amt_reg  <= amt_next;
        end
        if (cmd.expo)
        begin
            e_reg    <= e_next;
            mute_reg <= (level_now_reg == cfg.min_level);
        end
        if (cmd.interp)
        begin
            lo_reg     <= tab_lo;
            prod_reg   <= prod_next;
            s_reg      <= s_next;
            mute_p_reg <= mute_reg;
        end
        if (cmd.load_out)
        begin
            cur_out_reg  <= level_now_reg;
            goal_out_reg <= level_goal_reg;
            gain_out_reg <= gain_val;
        end
    end

    assign current_level = cur_out_reg;
    assign target_level  = goal_out_reg;
    assign linear_gain   = gain_out_reg;

endmodule

`default_nettype wire

// ===== sv/decibel_volume_ramp_top.sv =====
// ============================================================================
// decibel_volume_ramp_top
// Decibel-domain volume smoother with clamped target, slew-limited ramp and
// table-interpolated linear gain output.
// ============================================================================
// Path from input transfer to result valid: ramp step, exponent multiply,
//   table/slope multiply, output register (held while a result is unread);
//   capture is the transfer. The single-item sequencer in dvr_ctrl takes a
//   new item once the last is in the output register, also while a result waits to be read out.
// Reset (rst_n, asynchronous, active low): registers to -48 dB / 0 dB / 179,
//   both levels to -48 dB, channel idle with no result pending.
`default_nettype none

module decibel_volume_ramp_top
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    dvr_in_if.sink                              in_ch,
    dvr_out_if.source                           out_ch,
    input  wire logic                           wr_en,
    input  wire logic [1:0]                     wr_index,
    input  wire logic [dvr_pkg::LEVEL_W-1:0]    wr_data
);

    // configuration registers; the writer must keep writes to idle periods
    // (unchecked by the block) so the datapath sees them steady across an item
    dvr_pkg::cfg_t cfg_reg;
    dvr_pkg::cfg_t cfg_next;
    dvr_pkg::cmd_t cmd;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                dvr_pkg::REG_MIN_LEVEL: cfg_next.min_level = signed'(wr_data);
                dvr_pkg::REG_MAX_LEVEL: cfg_next.max_level = signed'(wr_data);
                dvr_pkg::REG_RAMP_STEP:
                    cfg_next.ramp_step = wr_data[dvr_pkg::STEP_W-1:0];
                default: cfg_next = cfg_reg;   // unused index: write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_level <= dvr_pkg::MIN_LEVEL_RESET;
            cfg_reg.max_level <= dvr_pkg::MAX_LEVEL_RESET;
            cfg_reg.ramp_step <= dvr_pkg::RAMP_STEP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // sequencer: one item in flight, result valid flag
    dvr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    // level state, ramp and gain arithmetic, result payload register
    dvr_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg           (cfg_reg),
        .func          (in_ch.func),
        .new_target    (in_ch.new_target),
        .sample_count  (in_ch.sample_count),
        .current_level (out_ch.current_level),
        .target_level  (out_ch.target_level),
        .linear_gain   (out_ch.linear_gain)
    );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ============================================================================
// testbench
// Self-checking bench for decibel_volume_ramp_top. It drives set-target and
// advance transfers, sweeps the three level/slope registers through several
// settings and back-pressures the result channel. Each report is checked
// field by field against an in-bench model of the ramp and the dB-to-linear
// gain table.
// ============================================================================

module testbench;

    import dvr_pkg::*;

    // ------------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------------
    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int DUT_LATENCY    = 4;
    localparam int IDLE_LIMIT     = 2000;   // cycles with no transfer or register write
    localparam int HOLDOFF_CYCLES = 300;
    localparam int PHASE_ITEMS    = 190;
    localparam int SWEEP_PHASES   = 7;

    // index 3 is not decoded by the block
    localparam logic [1:0] REG_SPARE = 2'd3;

    // gain maths: dB -> log2 factor and ln 2, both Q32
    localparam longint      DB_TO_LOG2_Q32 = 713378626;
    localparam logic [63:0] LN2_Q32        = 64'd2977044472;
    localparam int          SERIES_TERMS   = 20;
    localparam int          EXP_SHIFT      = 32 + FRAC_BITS;
    localparam int          POS_SHIFT      = 48;   // table position, Q48
    localparam int          REM_SHIFT      = 24;

    // legal level window and the full 24-bit extremes
    localparam logic signed [LEVEL_W-1:0] LEVEL_LO       = -24'sd6291456;
    localparam logic signed [LEVEL_W-1:0] LEVEL_HI       = 24'sd1572864;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MOST_NEG = 24'sh800000;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MOST_POS = 24'sh7FFFFF;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] current;
        logic signed [LEVEL_W-1:0] target;
        logic [GAIN_W-1:0]         gain;
    } level_report_t;

    typedef enum logic {SINK_OPEN, SINK_CHOPPY} sink_mode_t;

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the register write port
    // ------------------------------------------------------------------------
    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                wr_en    = 1'b0;
    logic [1:0]          wr_index = '0;
    logic [LEVEL_W-1:0]  wr_data  = '0;

    dvr_in_if  in_ch ();
    dvr_out_if out_ch ();

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    decibel_volume_ramp_top u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // ------------------------------------------------------------------------
    // Ramp model state: its own copy of the registers and both levels
    // ------------------------------------------------------------------------
    logic [31:0]               exp2_q30 [0:TAB_ENTRIES];
    logic signed [LEVEL_W-1:0] mdl_min;
    logic signed [LEVEL_W-1:0] mdl_max;
    logic [STEP_W-1:0]         mdl_step;
    logic signed [LEVEL_W-1:0] mdl_now;
    logic signed [LEVEL_W-1:0] mdl_goal;

    level_report_t pending_reports [$];
    int            fault_count = 0;

    // sender / receiver behaviour, steered by the test tasks
    bit         gaps_on     = 1'b1;
    int         burst_left  = 0;
    sink_mode_t sink_mode   = SINK_CHOPPY;
    int         holdoff_req = 0;

    // 2^(i/N) in Q30 from a Taylor series of exp(i*ln2/N) in Q32
    function automatic void fill_exp2_table();
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] sum;
        for (int i = 0; i <= TAB_ENTRIES; i++)
        begin
            y    = (LN2_Q32 * 64'(i)) / 64'(TAB_ENTRIES);
            term = 64'd1 << 32;
            sum  = term;
            for (int k = 1; k <= SERIES_TERMS; k++)
            begin
                term = ((term * y) >> 32) / 64'(k);
                sum  = sum + term;
            end
            exp2_q30[i] = 32'((sum + 64'd2) >> 2);
        end
    endfunction

    // 10^(dB/20) in Q4.16: split the log2 exponent into integer and fraction,
    // interpolate the mantissa from the table, then scale by 2^ip.
    // Above 2^14 it saturates; between 16x and that the top bits simply drop.
    function automatic logic [GAIN_W-1:0] db_to_linear(input logic signed [LEVEL_W-1:0] lv);
        logic [63:0] u;
        logic [63:0] frac;
        logic [63:0] pos;
        logic [63:0] idx;
        logic [63:0] rem;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mant;
        logic [63:0] scaled;
        longint      ip;
        longint      sh;
        u    = 64'(longint'(lv) * DB_TO_LOG2_Q32) + (64'd1 << 62);
        ip   = longint'(u >> EXP_SHIFT) - longint'((64'd1 << 62) >> EXP_SHIFT);
        frac = u & ((64'd1 << EXP_SHIFT) - 64'd1);
        pos  = frac * 64'(TAB_ENTRIES);
        idx  = pos >> POS_SHIFT;
        rem  = (pos >> REM_SHIFT) & 64'hFF_FFFF;
        if (idx >= 64'(TAB_ENTRIES))
        begin
            idx = 64'(TAB_ENTRIES - 1);
        end
        lo   = 64'(exp2_q30[idx]);
        hi   = 64'(exp2_q30[idx + 1]);
        mant = (hi >= lo) ? lo + (((hi - lo) * rem) >> REM_SHIFT) : lo;
        sh   = ip + FRAC_BITS - 30;
        if (sh >= 0)
        begin
            if (sh > 20)
            begin
                return GAIN_MAX;
            end
            scaled = mant << sh;
            return (scaled > 64'(GAIN_MAX)) ? GAIN_MAX : scaled[GAIN_W-1:0];
        end
        if (-sh >= 63)
        begin
            return '0;
        end
        scaled = mant >> (-sh);
        return scaled[GAIN_W-1:0];
    endfunction

    // Apply one item to the model and return the report it should produce.
    function automatic level_report_t apply_volume_item(input logic fn,
                                                        input logic signed [LEVEL_W-1:0] tgt,
                                                        input logic [COUNT_W-1:0] cnt);
        logic signed [LEVEL_W-1:0] clamped;
        longint                    amt;
        longint                    cur;
        level_report_t             rpt;
        if (fn == FUNC_SET)
        begin
            // floor first, then ceiling: inverted bounds end on max_level
            clamped = tgt;
            if (clamped < mdl_min)
            begin
                clamped = mdl_min;
            end
            if (clamped > mdl_max)
            begin
                clamped = mdl_max;
            end
            mdl_goal = clamped;
        end
        else
        begin
            amt = longint'(mdl_step) * longint'(cnt);
            cur = longint'(mdl_now);
            if (cur < longint'(mdl_goal))
            begin
                cur = cur + amt;
                if (cur > longint'(mdl_goal))
                begin
                    cur = longint'(mdl_goal);
                end
            end
            else
            begin
                cur = cur - amt;
                if (cur < longint'(mdl_goal))
                begin
                    cur = longint'(mdl_goal);
                end
            end
            mdl_now = LEVEL_W'(cur);
        end
        rpt.current = mdl_now;
        rpt.target  = mdl_goal;
        // sitting exactly on the floor mutes; anything else goes through the table
        rpt.gain    = (mdl_now == mdl_min) ? '0 : db_to_linear(mdl_now);
        return rpt;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Register write; the block is idle whenever this is called, so the model
    // copy can follow straight away.
    task automatic write_reg(input logic [1:0] idx, input logic [LEVEL_W-1:0] data);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        case (idx)
            REG_MIN_LEVEL: mdl_min  = data;
            REG_MAX_LEVEL: mdl_max  = data;
            REG_RAMP_STEP: mdl_step = data[STEP_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    // One input transfer. Valid is left high after the transfer so that
    // back-to-back items stream; whoever stops sending drops it via
    // drain_reports before the next rising edge.
    task automatic send_item(input logic fn, input logic [LEVEL_W-1:0] tgt,
                             input logic [COUNT_W-1:0] cnt);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            gap        = $urandom_range(0, 12);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                @(negedge clk);
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        @(negedge clk);
        in_ch.valid        <= 1'b1;
        in_ch.func         <= fn;
        in_ch.new_target   <= tgt;
        in_ch.sample_count <= cnt;
        do
            @(posedge clk);
        while (!in_ch.ready);
        pending_reports.push_back(apply_volume_item(fn, tgt, cnt));
    endtask

    // Stop offering items and wait for every outstanding report.
    task automatic drain_reports();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic signed [LEVEL_W-1:0] rand_level();
        return LEVEL_W'(int'(LEVEL_LO) +
                        int'($urandom_range(0, int'(LEVEL_HI) - int'(LEVEL_LO))));
    endfunction

    // Mostly a target inside the current window; now and then anything at all.
    function automatic logic signed [LEVEL_W-1:0] pick_target();
        int lo;
        int hi;
        lo = int'(mdl_min);
        hi = int'(mdl_max);
        if ($urandom_range(0, 9) < 2)
        begin
            return ($urandom_range(0, 1) != 0) ? rand_level() : LEVEL_W'($urandom());
        end
        if (hi < lo)
        begin
            return rand_level();
        end
        return LEVEL_W'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    // Short hops half the time so ramps take several advances to settle.
    function automatic logic [COUNT_W-1:0] pick_count();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
        begin
            return COUNT_W'($urandom_range(1, 64));
        end
        if (sel < 8)
        begin
            return COUNT_W'($urandom_range(65, 4096));
        end
        if (sel < 9)
        begin
            return COUNT_W'($urandom_range(4097, 8191));
        end
        return '0;
    endfunction

    // Well-formed ramps (a new target, then a run of advances with random
    // junk in the unused fields), plus a share of fully random items.
    task automatic run_ramp_sequences(input int n_items);
        int sent;
        int moves;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                send_item(1'($urandom_range(0, 1)), LEVEL_W'($urandom()),
                          COUNT_W'($urandom()));
                sent++;
            end
            else
            begin
                send_item(FUNC_SET, pick_target(), COUNT_W'($urandom()));
                moves = $urandom_range(1, 8);
                repeat (moves)
                begin
                    send_item(FUNC_ADVANCE, LEVEL_W'($urandom()), pick_count());
                end
                sent += 1 + moves;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset state, clamping at both bounds, zero count, overshoot, mute.
    task automatic test_directed_items();
        // both levels start on the floor: the gain is muted
        send_item(FUNC_ADVANCE, '0, 13'd1);
        // far above the ceiling, count field junk: lands on max_level
        send_item(FUNC_SET, LEVEL_MOST_POS, 13'h1FFF);
        // zero samples: nothing moves; unused target field at its extreme
        send_item(FUNC_ADVANCE, LEVEL_MOST_NEG, '0);
        send_item(FUNC_ADVANCE, LEVEL_MOST_NEG, 13'h1FFF);
        send_item(FUNC_ADVANCE, '0, 13'h1FFF);
        // this one would overshoot; it must stop on the target
        send_item(FUNC_ADVANCE, '1, 13'd4096);
        // levels equal: no change
        send_item(FUNC_ADVANCE, '0, 13'd1);
        // far below the floor: raised to min_level
        send_item(FUNC_SET, LEVEL_MOST_NEG, '0);
        repeat (3) send_item(FUNC_ADVANCE, LEVEL_MOST_POS, 13'd4096);
        send_item(FUNC_SET, LEVEL_LO, 13'd4096);
        // exactly on the ceiling, then a single-sample step up toward it
        send_item(FUNC_SET, MAX_LEVEL_RESET, '0);
        send_item(FUNC_ADVANCE, '0, 13'd1);
        send_item(FUNC_SET, -24'sd1, 13'h0AAA);
        send_item(FUNC_ADVANCE, 24'h555555, 13'd4095);
        send_item(FUNC_SET, 24'sd1, 13'h1555);
        send_item(FUNC_ADVANCE, 24'hAAAAAA, 13'd2048);
        send_item(FUNC_SET, MIN_LEVEL_RESET, '1);
        repeat (2) send_item(FUNC_ADVANCE, '0, 13'h1FFF);
        drain_reports();
    endtask

    // Register extremes: saturation, underflow, spare index, no re-clamp on a
    // bound change, inverted bounds, slowest and stalled slopes.
    task automatic test_register_extremes();
        // widest legal window, fastest slope; top data bits must be ignored
        write_reg(REG_MIN_LEVEL, LEVEL_LO);
        write_reg(REG_MAX_LEVEL, LEVEL_HI);
        write_reg(REG_RAMP_STEP, 24'hFF_FFFF);
        send_item(FUNC_SET, LEVEL_HI, '0);
        send_item(FUNC_ADVANCE, '0, 13'h1FFF);
        send_item(FUNC_SET, LEVEL_LO, '0);
        send_item(FUNC_ADVANCE, '0, 13'h1FFF);
        drain_reports();

        // full 24-bit window: saturates at the top, truncates to zero just
        // above the floor without being the mute case
        write_reg(REG_MIN_LEVEL, LEVEL_MOST_NEG);
        write_reg(REG_MAX_LEVEL, LEVEL_MOST_POS);
        send_item(FUNC_SET, LEVEL_MOST_POS, '0);
        send_item(FUNC_ADVANCE, '0, 13'h1FFF);
        send_item(FUNC_SET, LEVEL_MOST_NEG, '0);
        send_item(FUNC_ADVANCE, '0, 13'h1FFF);
        send_item(FUNC_SET, LEVEL_MOST_NEG + 24'sd1, '0);
        send_item(FUNC_ADVANCE, '0, 13'd1);
        drain_reports();

        // spare index: nothing may change
        write_reg(REG_SPARE, LEVEL_W'($urandom()));
        send_item(FUNC_ADVANCE, '0, 13'd1);
        drain_reports();

        // floor moved above the current level: stored levels stay put
        write_reg(REG_MIN_LEVEL, LEVEL_LO);
        send_item(FUNC_ADVANCE, '0, '0);
        drain_reports();

        // inverted bounds: every request ends on max_level
        write_reg(REG_MIN_LEVEL, LEVEL_HI);
        write_reg(REG_MAX_LEVEL, LEVEL_LO);
        send_item(FUNC_SET, rand_level(), '0);
        send_item(FUNC_SET, LEVEL_MOST_POS, '0);
        send_item(FUNC_ADVANCE, '0, 13'h1FFF);
        drain_reports();

        // slowest slope, then a zero slope with junk in the upper data bits
        write_reg(REG_MIN_LEVEL, MIN_LEVEL_RESET);
        write_reg(REG_MAX_LEVEL, MAX_LEVEL_RESET);
        write_reg(REG_RAMP_STEP, 24'd1);
        send_item(FUNC_SET, MAX_LEVEL_RESET, '0);
        send_item(FUNC_ADVANCE, '0, 13'h1FFF);
        drain_reports();
        write_reg(REG_RAMP_STEP, 24'hFF_0000);
        send_item(FUNC_ADVANCE, '0, 13'h1FFF);
        drain_reports();
        write_reg(REG_RAMP_STEP, {8'h00, RAMP_STEP_RESET});
    endtask

    // Sink goes quiet for a long stretch while the sender keeps streaming,
    // so the block fills and holds off its input; then the sender waits for
    // every report before carrying on.
    task automatic test_backpressure();
        gaps_on     = 1'b0;
        holdoff_req = HOLDOFF_CYCLES;
        run_ramp_sequences(24);
        drain_reports();
        gaps_on     = 1'b1;
    endtask

    // Random ramps across several register settings, extremes included.
    task automatic test_random_sweep();
        logic signed [LEVEL_W-1:0] lvl_a;
        logic signed [LEVEL_W-1:0] lvl_b;
        for (int ph = 0; ph < SWEEP_PHASES; ph++)
        begin
            drain_reports();
            lvl_a = rand_level();
            lvl_b = rand_level();
            case (ph)
                0:
                begin
                    write_reg(REG_MIN_LEVEL, MIN_LEVEL_RESET);
                    write_reg(REG_MAX_LEVEL, MAX_LEVEL_RESET);
                    write_reg(REG_RAMP_STEP, {8'h00, RAMP_STEP_RESET});
                end
                1:
                begin
                    write_reg(REG_MIN_LEVEL, LEVEL_LO);
                    write_reg(REG_MAX_LEVEL, LEVEL_HI);
                    write_reg(REG_RAMP_STEP, 24'd1);
                end
                2:
                begin
                    write_reg(REG_RAMP_STEP, 24'd65535);
                end
                3:
                begin
                    write_reg(REG_MIN_LEVEL, (lvl_a < lvl_b) ? lvl_a : lvl_b);
                    write_reg(REG_MAX_LEVEL, (lvl_a < lvl_b) ? lvl_b : lvl_a);
                    write_reg(REG_RAMP_STEP, LEVEL_W'($urandom_range(1, 65535)));
                end
                4:
                begin
                    // zero-width window
                    write_reg(REG_MIN_LEVEL, lvl_a);
                    write_reg(REG_MAX_LEVEL, lvl_a);
                end
                5:
                begin
                    write_reg(REG_MIN_LEVEL, (lvl_a < lvl_b) ? lvl_b : lvl_a);
                    write_reg(REG_MAX_LEVEL, (lvl_a < lvl_b) ? lvl_a : lvl_b);
                    write_reg(REG_RAMP_STEP, LEVEL_W'($urandom_range(1, 4000)));
                end
                default:
                begin
                    write_reg(REG_MIN_LEVEL, LEVEL_W'($urandom()));
                    write_reg(REG_MAX_LEVEL, LEVEL_W'($urandom()));
                    write_reg(REG_RAMP_STEP, LEVEL_W'($urandom()));
                end
            endcase
            // phase 2 streams flat out on both sides; phase 5 only opens the sink
            gaps_on   = (ph != 2);
            sink_mode = (ph == 2 || ph == 5) ? SINK_OPEN : SINK_CHOPPY;
            run_ramp_sequences(PHASE_ITEMS);
        end
        gaps_on   = 1'b1;
        sink_mode = SINK_CHOPPY;
    endtask

    // ------------------------------------------------------------------------
    // Result sink: alternating ready/stall runs, or a counted hold-off
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int hold_left;
        int run_left;
        bit run_ready;
        hold_left    = 0;
        run_left     = 0;
        run_ready    = 1'b0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoff_req > 0)
            begin
                hold_left   = holdoff_req;
                holdoff_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (sink_mode == SINK_OPEN)
            begin
                out_ch.ready <= 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    run_ready = !run_ready;
                    run_left  = run_ready ? $urandom_range(1, 12) : $urandom_range(1, 8);
                end
                run_left--;
                out_ch.ready <= run_ready;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Report checker: every result transfer against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : report_checker
        level_report_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                fault_count++;
                $display("%0t: unexpected report: current %0d target %0d gain %0d", $time,
                         out_ch.current_level, out_ch.target_level, out_ch.linear_gain);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (out_ch.current_level !== want.current)
                begin
                    fault_count++;
                    $display("%0t: current_level expected %0d, got %0d", $time,
                             want.current, out_ch.current_level);
                end
                if (out_ch.target_level !== want.target)
                begin
                    fault_count++;
                    $display("%0t: target_level expected %0d, got %0d", $time,
                             want.target, out_ch.target_level);
                end
                if (out_ch.linear_gain !== want.gain)
                begin
                    fault_count++;
                    $display("%0t: linear_gain expected %0d, got %0d", $time,
                             want.gain, out_ch.linear_gain);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any transfer or register write ends the run
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || wr_en || (in_ch.valid && in_ch.ready) ||
                (out_ch.valid && out_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : test_sequence
        in_ch.valid        = 1'b0;
        in_ch.func         = FUNC_ADVANCE;
        in_ch.new_target   = '0;
        in_ch.sample_count = '0;

        fill_exp2_table();
        mdl_min  = MIN_LEVEL_RESET;
        mdl_max  = MAX_LEVEL_RESET;
        mdl_step = RAMP_STEP_RESET;
        mdl_now  = MIN_LEVEL_RESET;
        mdl_goal = MIN_LEVEL_RESET;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_items();
        test_register_extremes();
        test_backpressure();
        test_random_sweep();

        // all stimulus in: wait out the last reports, then a few extra cycles
        // to catch anything the block emits on its own
        drain_reports();
        repeat (DUT_LATENCY * 4) @(posedge clk);
        if (fault_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/dvr_pkg.sv
sv/dvr_in_if.sv
sv/dvr_out_if.sv
sv/dvr_ctrl.sv
sv/dvr_datapath.sv
sv/decibel_volume_ramp_top.sv
tb/sv/testbench.sv
